// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned HdrBytes = 7;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);
  localparam int unsigned CfgIdxW  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_SYMBOL = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_STOP_SYMBOL  = 8'd1;

  localparam logic [ByteW-1:0] START_SYMBOL_RST = 8'd2;
  localparam logic [ByteW-1:0] STOP_SYMBOL_RST  = 8'd3;

  // Place of the declared length inside the header
  localparam int unsigned HdrLenPos = HdrBytes - 1;

  typedef enum logic [1:0] {
    KIND_CONTENT  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_MISMATCH = 2'd2
  } kind_e;

  // One result item; header byte 0 is the destination prefix
  typedef struct packed {
    logic [HdrBytes-1:0][ByteW-1:0] header;
    logic [ByteW-1:0]               byte_index;
    logic [ByteW-1:0]               data_byte;
    kind_e                          kind;
  } result_t;

endpackage

// ===== src/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Start/stop delimited frame deframer for a received byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer on the slave stream, one per clock
// cycle when the output side keeps up. A byte equal to the start symbol opens
// a frame; the next seven bytes are captured raw as the header (destination
// prefix, destination device, source prefix, source device, message type,
// message id, declared length). Every later byte leaves as a content result
// with its index, starting at 1, until the stop symbol closes the frame with
// a status result: accepted when the count equals the declared length,
// mismatch otherwise. The count saturates at 255. A start symbol inside the
// content reopens the frame without a result; bytes outside a frame give no
// result. Each result carries the header of the current frame. Results pass
// through a two-entry buffer; a byte is taken whenever it holds fewer than
// two results. A result enters the buffer as its byte is taken and shows on
// the master stream the cycle after if the buffer was empty. The user must
// write the symbols (config index 0 start, 1 stop, others dropped) only while
// the block is idle; the block does not enforce this. Config is always ready.
// ----------------------------------------------------------------------------
module serial_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream: tdata = rx_byte[7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata = data_byte[7:0], byte_index[15:8], dest_prefix[23:16],
  //   dest_device[31:24], src_prefix[39:32], src_device[47:40],
  //   msg_type[55:48], msg_id[63:56], msg_len[71:64]
  output logic [71:0]                   m_axis_tdata,
  // tuser = kind[1:0]
  output logic [1:0]                    m_axis_tuser,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfr_pkg::ByteW-1:0]     cfg_data_i
);

  logic [sfr_pkg::ByteW-1:0] start_symbol_q, stop_symbol_q;
  logic                      in_xfer;
  logic                      res_valid;
  sfr_pkg::result_t          res, out_res;

  // Configuration registers; the channel never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_symbol_q <= sfr_pkg::START_SYMBOL_RST;
      stop_symbol_q  <= sfr_pkg::STOP_SYMBOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sfr_pkg::CFG_START_SYMBOL: start_symbol_q <= cfg_data_i;
        sfr_pkg::CFG_STOP_SYMBOL:  stop_symbol_q  <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  sfr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (in_xfer),
    .byte_i         (s_axis_tdata),
    .start_symbol_i (start_symbol_q),
    .stop_symbol_i  (stop_symbol_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // Hold results here while the master side stalls
  sfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {out_res.header, out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

// ===== src/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// sfr_parser
// Frame state, header capture and byte count; forms the result of one byte.
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       byte_valid_i,
  input  logic [sfr_pkg::ByteW-1:0]  byte_i,
  input  logic [sfr_pkg::ByteW-1:0]  start_symbol_i,
  input  logic [sfr_pkg::ByteW-1:0]  stop_symbol_i,
  output logic                       res_valid_o,
  output sfr_pkg::result_t           res_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_HEADER  = 3'b010,
    ST_CONTENT = 3'b100
  } phase_e;

  localparam logic [sfr_pkg::HdrIdxW-1:0] HdrLast = sfr_pkg::HdrIdxW'(sfr_pkg::HdrBytes - 1);
  localparam logic [sfr_pkg::ByteW-1:0]   CountMax = '1;

  phase_e                                       phase_q, phase_d;
  logic [sfr_pkg::HdrIdxW-1:0]                  hdr_idx_q, hdr_idx_d;
  logic [sfr_pkg::ByteW-1:0]                    count_q, count_d;
  logic [sfr_pkg::HdrBytes-1:0][sfr_pkg::ByteW-1:0] header_q;
  logic                                         hdr_we;

  always_comb begin
    phase_d          = phase_q;
    hdr_idx_d        = hdr_idx_q;
    count_d          = count_q;
    hdr_we           = 1'b0;
    res_valid_o      = 1'b0;
    res_o.kind       = sfr_pkg::KIND_CONTENT;
    res_o.data_byte  = byte_i;
    res_o.byte_index = count_q;
    res_o.header     = header_q;
    if (byte_valid_i) begin
      case (phase_q)
        ST_IDLE: begin
          if (byte_i == start_symbol_i) begin
            phase_d   = ST_HEADER;
            hdr_idx_d = '0;
            count_d   = 8'd1;
          end
        end
        ST_HEADER: begin
          // take header bytes raw, symbols included
          hdr_we = 1'b1;
          if (hdr_idx_q == HdrLast) begin
            phase_d = ST_CONTENT;
          end else begin
            hdr_idx_d = hdr_idx_q + 1'b1;
          end
        end
        ST_CONTENT: begin
          if (byte_i == stop_symbol_i) begin
            res_valid_o     = 1'b1;
            res_o.data_byte = '0;
            res_o.kind      = (count_q == header_q[sfr_pkg::HdrLenPos]) ?
                              sfr_pkg::KIND_ACCEPT : sfr_pkg::KIND_MISMATCH;
            phase_d         = ST_IDLE;
          end else if (byte_i == start_symbol_i) begin
            // reopen the frame, no result
            phase_d   = ST_HEADER;
            hdr_idx_d = '0;
            count_d   = 8'd1;
          end else begin
            res_valid_o = 1'b1;
            if (count_q != CountMax) begin
              count_d = count_q + 1'b1;
            end
          end
        end
        default: begin
          phase_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ST_IDLE;
      hdr_idx_q <= '0;
      count_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      header_q[hdr_idx_q] <= byte_i;
    end
  end

endmodule

// ===== src/sfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// sfr_out_buf
// Two-entry result buffer; decouples the input side from output stalls.
// ----------------------------------------------------------------------------
module sfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfr_pkg::result_t push_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_ready_i,
  output sfr_pkg::result_t data_o
);

  sfr_pkg::result_t entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;
  logic             push, pop;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign push    = push_i && ready_o;
  assign pop     = valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== test/serial_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_tb
// Self-checking bench for the start/stop delimited frame deframer.
// ----------------------------------------------------------------------------
// Feeds byte streams through the slave stream and rebuilds the deframing in
// a checker class: header capture, content indexes, status with the count
// against the declared length, reopening, count saturation. Every master
// transfer is compared field by field with the oldest owed result. Symbols
// are changed between phases, including equal symbols and the byte extremes.
// Both sides idle in random bursts, but not in the equal-symbol or last phase.
// ----------------------------------------------------------------------------

class deframe_checker;
  localparam int unsigned PhIdle    = 0;
  localparam int unsigned PhContent = sfr_pkg::HdrBytes + 1;

  logic [7:0]       open_sym;
  logic [7:0]       close_sym;
  int unsigned      phase;
  logic [6:0][7:0]  hdr;
  logic [7:0]       count;
  sfr_pkg::result_t owed_results[$];
  int               errors;
  int               n_content;
  int               n_accept;
  int               n_mismatch;
  string            hdr_name[7] = '{"dest_prefix", "dest_device", "src_prefix",
                                    "src_device", "msg_type", "msg_id", "msg_len"};

  function new();
    open_sym   = sfr_pkg::START_SYMBOL_RST;
    close_sym  = sfr_pkg::STOP_SYMBOL_RST;
    phase      = PhIdle;
    hdr        = '0;
    count      = '0;
    errors     = 0;
    n_content  = 0;
    n_accept   = 0;
    n_mismatch = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [7:0] data);
    if (idx == sfr_pkg::CFG_START_SYMBOL) open_sym = data;
    else if (idx == sfr_pkg::CFG_STOP_SYMBOL) close_sym = data;
  endfunction

  // Advance the framing state by one accepted byte; queue its result, if any.
  function void deframe_byte(logic [7:0] b);
    sfr_pkg::result_t r;
    r.header = hdr;
    r.data_byte = '0;
    r.byte_index = count;
    if (phase == PhIdle) begin
      if (b == open_sym) begin
        phase = 1;
        count = 8'd1;
      end
    end else if (phase < PhContent) begin
      hdr[phase-1] = b;
      phase++;
    end else if (b == close_sym) begin
      // status: the count includes the start byte
      if (count == hdr[sfr_pkg::HdrLenPos]) begin
        r.kind = sfr_pkg::KIND_ACCEPT;
        n_accept++;
      end else begin
        r.kind = sfr_pkg::KIND_MISMATCH;
        n_mismatch++;
      end
      owed_results.push_back(r);
      phase = PhIdle;
    end else if (b == open_sym) begin
      // reopen without a result
      phase = 1;
      count = 8'd1;
    end else begin
      r.kind = sfr_pkg::KIND_CONTENT;
      r.data_byte = b;
      owed_results.push_back(r);
      n_content++;
      if (count != 8'hFF) count++;
    end
  endfunction

  task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (errors < 40) $display("mismatch %s: got 0x%02h, want 0x%02h", what, got, want);
    errors++;
  endtask

  task check_result(sfr_pkg::result_t got);
    sfr_pkg::result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch("result with none owed, kind", 8'(got.kind), 8'h00);
      return;
    end
    want = owed_results.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", 8'(got.kind), 8'(want.kind));
    if (got.data_byte !== want.data_byte)
      report_mismatch("data_byte", got.data_byte, want.data_byte);
    if (got.byte_index !== want.byte_index)
      report_mismatch("byte_index", got.byte_index, want.byte_index);
    for (int i = 0; i < sfr_pkg::HdrBytes; i++) begin
      if (got.header[i] !== want.header[i])
        report_mismatch(hdr_name[i], got.header[i], want.header[i]);
    end
  endtask

  task check_leftover();
    while (owed_results.size() != 0) begin
      report_mismatch("result never seen, kind", 8'h00,
                      8'(owed_results[0].kind));
      void'(owed_results.pop_front());
    end
  endtask
endclass

module serial_frame_receiver_tb;

  localparam int unsigned WatchdogLimit = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  deframe_checker checker_h = new();

  // Symbols currently programmed, used to shape the stimulus
  logic [7:0] cur_start;
  logic [7:0] cur_stop;
  // Percent chance of an idle burst; zero gives a stretch without idling
  int         idle_pct;
  int         n_sent;
  int         n_cfg;
  int         stall_left;
  int         quiet_cycles;

  serial_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // rx_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // data_byte, byte_index, header bytes 0..6
    .m_axis_tuser  (m_axis_tuser),   // kind
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Observe every transfer at the edge it happens; all drives are nonblocking,
  // so the values seen here are the ones from before the edge.
  always @(posedge clk_i) begin
    sfr_pkg::result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) checker_h.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) checker_h.deframe_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.header     = m_axis_tdata[71:16];
        got.byte_index = m_axis_tdata[15:8];
        got.data_byte  = m_axis_tdata[7:0];
        got.kind       = sfr_pkg::kind_e'(m_axis_tuser);
        checker_h.check_result(got);
      end
    end
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: give up once nothing has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("watchdog expired after %0d quiet cycles", quiet_cycles);
          $display("FAIL serial_frame_receiver");
          $finish;
        end
      end
    end
  end

  // Hold one byte on the slave stream until it is transferred. tvalid stays
  // high on return so that a following byte goes out without a bubble.
  task send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Drop tvalid and wait until every owed result has left, plus a margin for
  // a byte that causes no result still in flight.
  task settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (checker_h.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_cfg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_cfg++;
  endtask

  // Reprogram both symbols; optionally also hit an index past the list
  task set_symbols(input logic [7:0] start_b, input logic [7:0] stop_b, input bit stray);
    settle();
    write_cfg(sfr_pkg::CFG_START_SYMBOL, start_b);
    write_cfg(sfr_pkg::CFG_STOP_SYMBOL, stop_b);
    if (stray) write_cfg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
    cur_start = start_b;
    cur_stop  = stop_b;
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_start || b == cur_stop);
    return b;
  endfunction

  // Header bytes may equal either symbol; the declared length mostly fits
  task send_header(input int n_content);
    int         r;
    logic [7:0] len;
    for (int i = 0; i < sfr_pkg::HdrBytes - 1; i++) begin
      r = $urandom_range(0, 7);
      if (r == 0) send_byte(cur_start);
      else if (r == 1) send_byte(cur_stop);
      else send_byte(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 9);
    len = (n_content >= 254) ? 8'hFF : 8'(n_content + 1);
    if (r == 7) len = len + 8'd1;
    else if (r == 8) len = len - 8'd1;
    else if (r == 9) len = 8'($urandom_range(0, 255));
    send_byte(len);
  endtask

  task send_frame(input int n_content, input bit close);
    send_byte(cur_start);
    send_header(n_content);
    repeat (n_content) send_byte(pick_content());
    if (close) send_byte(cur_stop);
  endtask

  // Mostly well-formed frames, then reopened, truncated frames and noise
  task send_chunk();
    int r;
    int len;
    r = $urandom_range(0, 19);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    if (r <= 13) begin
      send_frame(len, 1'b1);
    end else if (r <= 15) begin
      send_frame($urandom_range(0, 5), 1'b0);
      send_frame(len, 1'b1);
    end else if (r == 16) begin
      send_byte(cur_start);
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0) send_byte(cur_stop);
        else send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task run_items(input int n);
    int target;
    target = n_sent + n;
    while (n_sent < target) send_chunk();
  endtask

  initial begin
    int waited;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    m_axis_tready <= 1'b0;
    idle_pct      = 0;
    n_sent        = 0;
    n_cfg         = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset symbols, directed: stop and noise outside a frame, symbols and
    // byte extremes inside a header, an accepted and a mismatched frame
    set_symbols(sfr_pkg::START_SYMBOL_RST, sfr_pkg::STOP_SYMBOL_RST, 1'b0);
    idle_pct = 15;
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h02); send_byte(8'h03);
    send_byte(8'hAA); send_byte(8'h55); send_byte(8'h03);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'h02);
    send_byte(8'h01); send_byte(8'h80); send_byte(8'h7F); send_byte(8'hFE);
    send_byte(8'h10); send_byte(8'h20); send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h03);
    run_items(300);

    // Random distinct symbols under heavy idling, plus a write past the list
    set_symbols(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)), 1'b1);
    idle_pct = 40;
    run_items(300);

    // Equal symbols: open while idle, close while in content
    begin
      logic [7:0] same;
      same = 8'($urandom_range(0, 255));
      set_symbols(same, same, 1'b0);
    end
    idle_pct = 0;
    run_items(200);

    // Extremes, with frames long enough to saturate the count
    set_symbols(8'h00, 8'hFF, 1'b1);
    idle_pct = 15;
    send_frame(260, 1'b1);
    send_frame(256, 1'b1);
    run_items(150);

    // Swapped extremes; no idling on either side to the end
    set_symbols(8'hFF, 8'h00, 1'b0);
    idle_pct = 0;
    run_items(180);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (checker_h.owed_results.size() != 0 && waited < 500) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    checker_h.check_leftover();

    $display("sent %0d bytes over 5 symbol settings with %0d register writes",
             n_sent, n_cfg);
    $display("checked %0d content, %0d accepted and %0d mismatch results",
             checker_h.n_content, checker_h.n_accept, checker_h.n_mismatch);
    if (checker_h.errors == 0) begin
      $display("PASS serial_frame_receiver");
    end else begin
      $display("FAIL serial_frame_receiver");
    end
    $finish;
  end

endmodule
